// ----- src/rrb_pkg.sv -----
// Shared types and codes for the registration retry sequencer.
// Holds request/result payload structs, phase and status codes, and config layout.
// No dependencies; every other source file depends on this package.
package rrb_pkg;

  // Time base for deadlines (48 bits)
  localparam int unsigned TimeWidth     = 48;
  localparam int unsigned ShiftBits     = $clog2(TimeWidth);
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned NowWidth      = 48;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef logic [TimeWidth-1:0]  time_t;
  typedef logic [CountWidth-1:0] count_t;

  // Phase codes
  localparam logic [3:0] PhIdle        = 4'd0;
  localparam logic [3:0] PhConnect     = 4'd1;
  localparam logic [3:0] PhRegister    = 4'd2;
  localparam logic [3:0] PhError       = 4'd3;
  localparam logic [3:0] PhDisconnect  = 4'd4;
  localparam logic [3:0] PhCleanup     = 4'd5;
  localparam logic [3:0] PhCleanupFail = 4'd6;
  localparam logic [3:0] PhWait        = 4'd7;
  localparam logic [3:0] PhFailed      = 4'd8;

  // Operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // Outcome codes
  localparam logic [1:0] ConnOk    = 2'd0;
  localparam logic [1:0] ConnBusy  = 2'd1;
  localparam logic [1:0] ReqDone   = 2'd0;
  localparam logic [1:0] ReqBusy   = 2'd1;
  localparam logic       CloseBusy = 1'b1;

  // Link status codes
  localparam logic [1:0] StatNone       = 2'd0;
  localparam logic [1:0] StatRegistered = 2'd1;
  localparam logic [1:0] StatBootstrap  = 2'd2;
  localparam logic [1:0] StatFailure    = 2'd3;

  // Config register indexes
  localparam logic [CfgIndexWidth-1:0] CfgAttemptLimit   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRetryBase      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSequenceDelay  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgSequenceLimit  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgBootstrapOnFail = 3'd4;

  typedef struct packed {
    logic                operation;
    logic                model_ok;
    logic [1:0]          connect_outcome;
    logic [1:0]          request_outcome;
    logic                close_outcome;
    logic [NowWidth-1:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic       next_action;
    logic [1:0] link_status;
    logic       start_error;
    logic       do_connect;
    logic       do_close;
    logic       close_with_cleanup;
    logic [3:0] phase;
    count_t     attempt_number;
    count_t     sequence_number;
  } rsp_t;

  typedef struct packed {
    count_t      attempt_limit;
    logic [31:0] retry_base_seconds;
    logic [31:0] sequence_delay_seconds;
    count_t      sequence_limit;
    logic        bootstrap_on_fail;
  } cfg_t;

  // Control for the deadline unit
  typedef struct packed {
    count_t shift;
    logic   use_sequence_delay;
  } dl_ctrl_t;

endpackage

// ----- src/rrb_if.sv -----
// Valid/ready channel interfaces for the registration retry sequencer.
// Request, result and config write channels; depends on rrb_pkg.
interface rrb_req_if;
  logic          valid;
  logic          ready;
  rrb_pkg::req_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface rrb_rsp_if;
  logic          valid;
  logic          ready;
  rrb_pkg::rsp_t result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface rrb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rrb_pkg::CfgIndexWidth-1:0]   index;
  logic [rrb_pkg::CfgDataWidth-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/registration_retry_backoff_fsm_core.sv -----
// Top level of the registration retry sequencer.
// Input register, phase machine and result register; depends on rrb_pkg,
// rrb_if, rrb_cfg_regs and rrb_step.
//
// Usage:
//   req_i  - request channel: a start or a step item with the connect,
//            request and close outcomes and the current time.
//   rsp_o  - result channel: exactly one result per request, in order.
//   cfg_i  - config write channel (index, data), always ready; write only
//            while no request is in flight.
// Pipeline: two register stages (input register, then result register).
// Throughput: one request per cycle while rsp_o is not held; the phase
//   machine updates state once per request, input register to result register.
// Stall: while rsp_o is held, one more request may still sit in the input
//   register; after that req_i.ready drops until the result is taken.
// Reset: phase idle, counters and deadline cleared, config at its defaults
//   (5 attempts, 60 s base, 86400 s sequence delay, 1 sequence, bootstrap).
module registration_retry_backoff_fsm_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrb_req_if.sink   req_i,
  rrb_rsp_if.source rsp_o,
  rrb_cfg_if.sink   cfg_i
);
  import rrb_pkg::*;

  logic in_valid_q, in_valid_d;
  req_t in_item_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_result_q;
  rsp_t step_result;
  cfg_t cfg;
  logic advance;
  logic accept;

  rrb_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: move stage 1 into the result register when it is free or its result is taken
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  rrb_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  // Stage valid tracking
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= req_i.item;
    end
    if (advance) begin
      out_result_q <= step_result;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_result_q;

endmodule

// ----- src/rrb_cfg_regs.sv -----
// Configuration register file for the registration retry sequencer.
// Decodes writes from the config channel; depends on rrb_pkg and rrb_if.
module rrb_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrb_cfg_if.sink       cfg_i,
  output rrb_pkg::cfg_t cfg_o
);
  import rrb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always accepted
  assign cfg_i.ready = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgAttemptLimit:    cfg_d.attempt_limit = cfg_i.data[CountWidth-1:0];
        CfgRetryBase:       cfg_d.retry_base_seconds = cfg_i.data;
        CfgSequenceDelay:   cfg_d.sequence_delay_seconds = cfg_i.data;
        CfgSequenceLimit:   cfg_d.sequence_limit = cfg_i.data[CountWidth-1:0];
        CfgBootstrapOnFail: cfg_d.bootstrap_on_fail = cfg_i.data[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attempt_limit          <= 16'd5;
      cfg_q.retry_base_seconds     <= 32'd60;
      cfg_q.sequence_delay_seconds <= 32'd86400;
      cfg_q.sequence_limit         <= 16'd1;
      cfg_q.bootstrap_on_fail      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/rrb_deadline.sv -----
// Deadline arithmetic: saturating back-off shift, saturating add to now,
// and the expiry compare. Pure logic; depends on rrb_pkg.
module rrb_deadline (
  input  rrb_pkg::dl_ctrl_t ctrl_i,
  input  logic [31:0]       retry_base_i,
  input  logic [31:0]       sequence_delay_i,
  input  rrb_pkg::time_t    now_i,
  input  rrb_pkg::time_t    deadline_i,
  output rrb_pkg::time_t    deadline_o,
  output logic              expired_o
);
  import rrb_pkg::*;

  localparam int unsigned WideWidth = TimeWidth + 32;

  logic [WideWidth-1:0] shifted;
  time_t                backoff;
  time_t                delay;
  logic [TimeWidth:0]   sum;

  // base * 2^shift, clipped to the time range
  always_comb begin
    shifted = WideWidth'(retry_base_i) << ctrl_i.shift[ShiftBits-1:0];
    priority if (retry_base_i == 32'd0) begin
      backoff = '0;
    end else if (ctrl_i.shift >= CountWidth'(TimeWidth)) begin
      backoff = '1;
    end else if (shifted[WideWidth-1:TimeWidth] != '0) begin
      backoff = '1;
    end else begin
      backoff = shifted[TimeWidth-1:0];
    end
  end

  // now + delay, clipped on carry out
  assign delay = ctrl_i.use_sequence_delay ? TimeWidth'(sequence_delay_i) : backoff;
  assign sum   = {1'b0, now_i} + {1'b0, delay};
  assign deadline_o = sum[TimeWidth] ? '1 : sum[TimeWidth-1:0];

  assign expired_o = deadline_i < now_i;

endmodule

// ----- src/rrb_step.sv -----
// Phase machine and counters of the registration retry sequencer.
// Advances state once per fired request and forms its result;
// depends on rrb_pkg and rrb_deadline.
module rrb_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  rrb_pkg::req_t item_i,
  input  rrb_pkg::cfg_t cfg_i,
  output rrb_pkg::rsp_t result_o
);
  import rrb_pkg::*;

  logic [3:0] phase_q, phase_d;
  count_t     attempt_q, attempt_d;
  count_t     sequence_q, sequence_d;
  time_t      deadline_q, deadline_d;

  count_t     attempt_inc;
  count_t     sequence_inc;
  logic       attempts_left;
  time_t      now;
  time_t      new_deadline;
  logic       expired;
  dl_ctrl_t   dl_ctrl;

  assign now          = TimeWidth'(item_i.now_seconds);
  assign attempt_inc  = (attempt_q == '1) ? attempt_q : attempt_q + 1'b1;
  assign sequence_inc = (sequence_q == '1) ? sequence_q : sequence_q + 1'b1;
  assign attempts_left = attempt_inc < cfg_i.attempt_limit;

  // Back-off exponent is the new attempt count minus one
  assign dl_ctrl.shift              = attempt_inc - 1'b1;
  assign dl_ctrl.use_sequence_delay = !attempts_left;

  rrb_deadline u_deadline (
    .ctrl_i           (dl_ctrl),
    .retry_base_i     (cfg_i.retry_base_seconds),
    .sequence_delay_i (cfg_i.sequence_delay_seconds),
    .now_i            (now),
    .deadline_i       (deadline_q),
    .deadline_o       (new_deadline),
    .expired_o        (expired)
  );

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    attempt_d  = attempt_q;
    sequence_d = sequence_q;
    deadline_d = deadline_q;
    result_o   = '0;

    if (item_i.operation == OpStart) begin
      if (item_i.model_ok) begin
        phase_d    = PhConnect;
        attempt_d  = '0;
        sequence_d = '0;
        deadline_d = '0;
      end else begin
        result_o.start_error = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhConnect: begin
          result_o.do_connect = 1'b1;
          if (item_i.connect_outcome != ConnBusy) begin
            phase_d = (item_i.connect_outcome == ConnOk) ? PhRegister : PhError;
            result_o.next_action = 1'b1;
          end
        end
        PhRegister: begin
          if (item_i.request_outcome != ReqBusy) begin
            if (item_i.request_outcome == ReqDone) begin
              result_o.link_status = StatRegistered;
            end else begin
              phase_d = PhError;
            end
            result_o.next_action = 1'b1;
          end
        end
        PhError: begin
          attempt_d = attempt_inc;
          if (attempts_left) begin
            deadline_d = new_deadline;
            phase_d    = PhDisconnect;
          end else begin
            sequence_d = sequence_inc;
            if (sequence_inc >= cfg_i.sequence_limit) begin
              phase_d = PhCleanupFail;
            end else begin
              deadline_d = new_deadline;
              attempt_d  = '0;
              phase_d    = PhCleanup;
            end
          end
          result_o.next_action = 1'b1;
        end
        PhDisconnect, PhCleanup, PhCleanupFail: begin
          result_o.do_close           = 1'b1;
          result_o.close_with_cleanup = (phase_q != PhDisconnect);
          if (item_i.close_outcome != CloseBusy) begin
            phase_d = (phase_q == PhCleanupFail) ? PhFailed : PhWait;
            result_o.next_action = 1'b1;
          end
        end
        PhWait: begin
          if (expired) begin
            phase_d = PhConnect;
            result_o.next_action = 1'b1;
          end
        end
        PhFailed: begin
          result_o.link_status = cfg_i.bootstrap_on_fail ? StatBootstrap : StatFailure;
          result_o.next_action = 1'b1;
        end
        // idle and unused codes do nothing
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    result_o.phase           = phase_d;
    result_o.attempt_number  = attempt_d;
    result_o.sequence_number = sequence_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      attempt_q  <= '0;
      sequence_q <= '0;
      deadline_q <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      attempt_q  <= attempt_d;
      sequence_q <= sequence_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

// ----- src/rrb_checker.sv -----
// Port-level assertions for the registration retry sequencer, bound to
// the top level. Depends on rrb_pkg.
module rrb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input rrb_pkg::rsp_t rsp_result_i
);
  import rrb_pkg::*;

  // A held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // Cleanup flag only travels with a close
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_result_i.do_close |-> !rsp_result_i.close_with_cleanup)
    else $error("cleanup without close");

  // Connect and close never issued together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_result_i.do_connect && rsp_result_i.do_close))
    else $error("connect and close in one step");

  // Rejected start leaves everything quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_result_i.start_error |->
      !rsp_result_i.next_action && rsp_result_i.link_status == StatNone)
    else $error("rejected start reported activity");

  // Registered status only in the register phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_result_i.link_status == StatRegistered |->
      rsp_result_i.phase == PhRegister)
    else $error("registered outside register phase");

endmodule

bind registration_retry_backoff_fsm_core rrb_checker u_rrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_result_i (rsp_o.result)
);

// ----- tb/sv/registration_retry_backoff_fsm_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for registration_retry_backoff_fsm_core: directed and random
// start/step requests, with per-request results predicted in the bench and checked in order.
// Depends on rrb_pkg, rrb_if and the RTL of the sequencer.
module registration_retry_backoff_fsm_core_tb;
  import rrb_pkg::*;

  // Outcome codes the package leaves unnamed
  localparam logic [1:0] ConnFail    = 2'd2;
  localparam logic [1:0] ConnUnknown = 2'd3;
  localparam logic [1:0] ReqError    = 2'd2;
  localparam logic [1:0] ReqRefused  = 2'd3;
  localparam logic       CloseDone   = 1'b0;
  localparam time_t      TimeMax     = {TimeWidth{1'b1}};
  localparam int         RandomRounds = 8;
  localparam int         ItemsPerRound = 250;

  logic clk_i;
  logic rst_ni;

  rrb_req_if req_if ();
  rrb_rsp_if rsp_if ();
  rrb_cfg_if cfg_if ();

  registration_retry_backoff_fsm_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Predicted sequencer state and its copy of the config
  logic [3:0] link_phase;
  count_t     tries;
  count_t     rounds;
  time_t      retry_due;
  count_t     cfg_tries_max;
  logic [31:0] cfg_base_s;
  logic [31:0] cfg_round_delay_s;
  count_t     cfg_rounds_max;
  logic       cfg_bootstrap;

  req_t  pending_items[$];
  rsp_t  due_results[$];
  time_t gen_now;
  int    failures;
  int    items_sent;
  int    results_seen;
  int    src_wait;
  int    snk_wait;
  int    hold_left;
  bit    src_idle;
  bit    snk_idle;

  // Clock: 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic time_t sat_add(time_t n, time_t d);
    if (d > TimeMax - n) return TimeMax;
    return n + d;
  endfunction

  // base * 2^shift, clipped to the time range
  function automatic time_t backoff_secs(logic [31:0] base, count_t shift);
    if (base == '0) return '0;
    if (shift >= TimeWidth) return TimeMax;
    if (time_t'(base) > (TimeMax >> shift)) return TimeMax;
    return time_t'(base) << shift;
  endfunction

  // One request through the phase machine; updates the predicted state
  function automatic rsp_t predict_retry_step(req_t it);
    rsp_t  r;
    time_t n;
    r = '0;
    n = it.now_seconds;
    if (it.operation == OpStart) begin
      if (it.model_ok) begin
        link_phase = PhConnect;
        tries      = '0;
        rounds     = '0;
        retry_due  = '0;
      end else begin
        r.start_error = 1'b1;
      end
    end else begin
      case (link_phase)
        PhConnect: begin
          r.do_connect = 1'b1;
          if (it.connect_outcome != ConnBusy) begin
            link_phase    = (it.connect_outcome == ConnOk) ? PhRegister : PhError;
            r.next_action = 1'b1;
          end
        end
        PhRegister: begin
          if (it.request_outcome != ReqBusy) begin
            if (it.request_outcome == ReqDone) r.link_status = StatRegistered;
            else link_phase = PhError;
            r.next_action = 1'b1;
          end
        end
        PhError: begin
          tries = sat_inc(tries);
          if (tries < cfg_tries_max) begin
            retry_due  = sat_add(n, backoff_secs(cfg_base_s, tries - 1'b1));
            link_phase = PhDisconnect;
          end else begin
            rounds = sat_inc(rounds);
            if (rounds >= cfg_rounds_max) begin
              link_phase = PhCleanupFail;
            end else begin
              retry_due  = sat_add(n, time_t'(cfg_round_delay_s));
              tries      = '0;
              link_phase = PhCleanup;
            end
          end
          r.next_action = 1'b1;
        end
        PhDisconnect, PhCleanup, PhCleanupFail: begin
          r.do_close           = 1'b1;
          r.close_with_cleanup = (link_phase != PhDisconnect);
          if (it.close_outcome != CloseBusy) begin
            link_phase    = (link_phase == PhCleanupFail) ? PhFailed : PhWait;
            r.next_action = 1'b1;
          end
        end
        PhWait: begin
          if (retry_due < n) begin
            link_phase    = PhConnect;
            r.next_action = 1'b1;
          end
        end
        PhFailed: begin
          r.link_status = cfg_bootstrap ? StatBootstrap : StatFailure;
          r.next_action = 1'b1;
        end
        default: ;
      endcase
    end
    r.phase           = link_phase;
    r.attempt_number  = tries;
    r.sequence_number = rounds;
    return r;
  endfunction

  function automatic req_t start_item(logic ok);
    req_t it;
    it                 = '0;
    it.operation       = OpStart;
    it.model_ok        = ok;
    it.connect_outcome = 2'($urandom_range(0, 3));
    it.request_outcome = 2'($urandom_range(0, 3));
    it.close_outcome   = 1'($urandom_range(0, 1));
    it.now_seconds     = NowWidth'({$urandom, $urandom});
    return it;
  endfunction

  function automatic req_t step_item(logic [1:0] conn, logic [1:0] rq, logic clo, time_t n);
    req_t it;
    it                 = '0;
    it.operation       = OpStep;
    it.model_ok        = 1'($urandom_range(0, 1));
    it.connect_outcome = conn;
    it.request_outcome = rq;
    it.close_outcome   = clo;
    it.now_seconds     = n;
    return it;
  endfunction

  // Random request; time mostly creeps forward with occasional large jumps
  function automatic req_t random_item();
    int         pick;
    logic [1:0] conn;
    logic [1:0] rq;
    logic       clo;
    pick = $urandom_range(0, 99);
    if (pick < 60) gen_now = gen_now + time_t'($urandom_range(0, 3));
    else if (pick < 85) gen_now = gen_now + time_t'($urandom_range(0, 200));
    else if (pick < 93) gen_now = gen_now + time_t'($urandom);
    else if (pick < 97) gen_now = time_t'({$urandom, $urandom});
    else gen_now = TimeMax - time_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    conn = (pick < 6) ? ConnOk : (pick == 6) ? ConnBusy : (pick < 9) ? ConnFail : ConnUnknown;
    pick = $urandom_range(0, 9);
    rq = (pick < 3) ? ReqDone : (pick < 5) ? ReqBusy : (pick < 8) ? ReqError : ReqRefused;
    clo = ($urandom_range(0, 3) == 0) ? CloseBusy : CloseDone;
    if ($urandom_range(0, 24) == 0) return start_item($urandom_range(0, 7) != 0);
    return step_item(conn, rq, clo, gen_now);
  endfunction

  function automatic void flag_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) flag_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
  endfunction

  function automatic void check_result(rsp_t got);
    rsp_t want;
    if (due_results.size() == 0) begin
      flag_failure($sformatf("result %h with no request outstanding", got));
      return;
    end
    want = due_results.pop_front();
    cmp_field("next_action", 16'(want.next_action), 16'(got.next_action));
    cmp_field("link_status", 16'(want.link_status), 16'(got.link_status));
    cmp_field("start_error", 16'(want.start_error), 16'(got.start_error));
    cmp_field("do_connect", 16'(want.do_connect), 16'(got.do_connect));
    cmp_field("do_close", 16'(want.do_close), 16'(got.do_close));
    cmp_field("close_with_cleanup", 16'(want.close_with_cleanup),
              16'(got.close_with_cleanup));
    cmp_field("phase", 16'(want.phase), 16'(got.phase));
    cmp_field("attempt_number", want.attempt_number, got.attempt_number);
    cmp_field("sequence_number", want.sequence_number, got.sequence_number);
  endfunction

  // Request driver: per-request gap, valid held until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.item  <= '0;
      src_wait = 0;
      src_idle = 1'b1;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(predict_retry_step(req_if.item));
        items_sent++;
        if (items_sent % 64 == 0) src_idle = ($urandom_range(0, 2) != 0);
        src_wait = src_idle ? $urandom_range(0, 15) : 0;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          req_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          req_if.item  <= pending_items.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks in order, random stalls and an occasional long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      snk_wait  = 0;
      hold_left = 0;
      snk_idle  = 1'b1;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_result(rsp_if.result);
        results_seen++;
        if (results_seen % 64 == 0) snk_idle = ($urandom_range(0, 2) != 0);
        if (results_seen % 600 == 300) hold_left = 150 + $urandom_range(0, 100);
        snk_wait = snk_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Config write; the predictor copy follows at the accepting edge
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CfgAttemptLimit:    cfg_tries_max     = val[15:0];
      CfgRetryBase:       cfg_base_s        = val;
      CfgSequenceDelay:   cfg_round_delay_s = val;
      CfgSequenceLimit:   cfg_rounds_max    = val[15:0];
      CfgBootstrapOnFail: cfg_bootstrap     = val[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_settings(count_t lim, logic [31:0] base, logic [31:0] delay,
                                count_t rounds_lim, logic boot);
    write_reg(CfgAttemptLimit, 32'(lim));
    write_reg(CfgRetryBase, base);
    write_reg(CfgSequenceDelay, delay);
    write_reg(CfgSequenceLimit, 32'(rounds_lim));
    write_reg(CfgBootstrapOnFail, 32'(boot));
  endtask

  // Wait until every request is sent and answered, then let the pipeline settle
  task automatic drain();
    while (pending_items.size() != 0 || req_if.valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.item   = '0;
    rsp_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    link_phase    = PhIdle;
    tries         = '0;
    rounds        = '0;
    retry_due     = '0;
    cfg_tries_max = 16'd5;
    cfg_base_s    = 32'd60;
    cfg_round_delay_s = 32'd86400;
    cfg_rounds_max = 16'd1;
    cfg_bootstrap = 1'b1;
    gen_now       = '0;
    failures      = 0;
    items_sent    = 0;
    results_seen  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset config: idle step, bad start, one retry with back-off
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, '0));
    pending_items.push_back(start_item(1'b0));
    pending_items.push_back(start_item(1'b1));
    pending_items.push_back(step_item(ConnBusy, ReqDone, CloseDone, 48'd10));
    pending_items.push_back(step_item(ConnUnknown, ReqDone, CloseDone, 48'd20));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1000));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseBusy, 48'd1001));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1002));
    // deadline equal to now keeps waiting, one past it reconnects
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1060));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1061));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1062));
    pending_items.push_back(step_item(ConnOk, ReqBusy, CloseDone, 48'd1063));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd1064));
    pending_items.push_back(step_item(ConnOk, ReqRefused, CloseDone, 48'd1065));
    // deadline clipped at the top of the time range
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, TimeMax));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, TimeMax));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, TimeMax));
    pending_items.push_back(start_item(1'b1));
    pending_items.push_back(step_item(ConnFail, ReqError, CloseDone, 48'd5));
    drain();

    // Directed: one attempt, two sequences, report failure
    apply_settings(16'd1, 32'hFFFF_FFFF, 32'd0, 16'd2, 1'b0);
    @(negedge clk_i);
    pending_items.push_back(start_item(1'b1));
    pending_items.push_back(step_item(ConnFail, ReqDone, CloseDone, 48'd400));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd500));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseBusy, 48'd500));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd500));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd501));
    pending_items.push_back(step_item(ConnFail, ReqDone, CloseDone, 48'd502));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd503));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd504));
    pending_items.push_back(step_item(ConnOk, ReqDone, CloseDone, 48'd505));
    drain();

    // Random rounds, each under its own config
    for (int p = 0; p < RandomRounds; p++) begin
      case (p)
        0: apply_settings(16'd5, 32'd60, 32'd86400, 16'd1, 1'b1);
        1: apply_settings(16'd0, 32'd0, 32'd0, 16'd0, 1'b0);
        2: apply_settings('1, '1, '1, '1, 1'b1);
        3: apply_settings(16'd1, 32'd1, 32'd1, 16'd1, 1'b0);
        default: apply_settings(count_t'($urandom_range(1, 6)), $urandom_range(0, 10),
                                $urandom_range(0, 30), count_t'($urandom_range(0, 4)),
                                1'($urandom_range(0, 1)));
      endcase
      @(negedge clk_i);
      for (int i = 0; i < ItemsPerRound; i++) pending_items.push_back(random_item());
      drain();
    end

    if (failures == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rrb_pkg.sv
src/rrb_if.sv
src/rrb_cfg_regs.sv
src/rrb_deadline.sv
src/rrb_step.sv
src/registration_retry_backoff_fsm_core.sv
src/rrb_checker.sv
tb/sv/registration_retry_backoff_fsm_core_tb.sv
